[src/ipc_pkg.sv]
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the IP address text classifier.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // ASCII codes the classifier recognizes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Group and separator limits
    localparam logic [1:0] DOT_MAX      = 2'd3;    // four IPv4 groups
    localparam logic [2:0] COLON_MAX    = 3'd7;    // eight IPv6 groups
    localparam logic [2:0] V4_MAX_LEN   = 3'd3;
    localparam logic [2:0] V6_MAX_LEN   = 3'd4;
    localparam logic [2:0] LEN_SAT      = 3'd7;
    localparam logic [9:0] V4_MAX_VALUE = 10'd255;
    localparam logic [9:0] VALUE_SAT    = 10'd256;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_HEX,
        CLS_DOT,
        CLS_COLON,
        CLS_OTHER
    } ipc_class_t;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_V4   = 2'd1,
        VERDICT_V6   = 2'd2
    } ipc_verdict_t;

    // One classified byte as it travels from front to back
    typedef struct packed {
        ipc_class_t cls;
        logic [3:0] digit;
        logic       last;
    } ipc_item_t;

endpackage

[src/ipc_front.sv]
// ----------------------------------------------------------------------------
// ipc_front
// Accepts address bytes and decodes each into a character class.
// ----------------------------------------------------------------------------
module ipc_front (
    input  logic                ch_push,
    input  logic [7:0]          ch,
    input  logic                last,
    input  logic                q_full,
    output logic                wr_en,
    output ipc_pkg::ipc_item_t  wr_item
);
    import ipc_pkg::*;

    logic [7:0] ch_offset;

    assign ch_offset = ch - CHAR_ZERO;
    assign wr_en     = ch_push && !q_full;

    always_comb
    begin
        wr_item.digit = ch_offset[3:0];
        wr_item.last  = last;
        unique case (ch) inside
            [CHAR_ZERO:CHAR_NINE]: wr_item.cls = CLS_DIGIT;
            [CHAR_LC_A:CHAR_LC_F],
            [CHAR_UC_A:CHAR_UC_F]: wr_item.cls = CLS_HEX;
            CHAR_DOT:              wr_item.cls = CLS_DOT;
            CHAR_COLON:            wr_item.cls = CLS_COLON;
            default:               wr_item.cls = CLS_OTHER;
        endcase
    end

endmodule

[src/ipc_fifo.sv]
// ----------------------------------------------------------------------------
// ipc_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ipc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ipc_pkg::ipc_item_t  wr_item,
    input  logic                rd_en,
    output logic                q_full,
    output logic                q_valid,
    output ipc_pkg::ipc_item_t  rd_item
);
    import ipc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipc_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // occupancy stays in range
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // simultaneous write and read leaves occupancy unchanged
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && do_rd) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved on write with read");

endmodule

[src/ipc_back.sv]
// ----------------------------------------------------------------------------
// ipc_back
// Tracks group and separator state and issues the verdict on the final byte.
// ----------------------------------------------------------------------------
module ipc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ipc_pkg::ipc_item_t  rd_item,
    output logic                rd_en,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          verdict
);
    import ipc_pkg::*;

    logic        v4_reg, v4_next;
    logic        v6_reg, v6_next;
    logic [1:0]  dot_reg, dot_next;
    logic [2:0]  colon_reg, colon_next;
    logic [2:0]  len_reg, len_next;
    logic [9:0]  value_reg, value_next;
    logic        lz_reg, lz_next;
    logic        res_valid_reg, res_valid_next;
    ipc_verdict_t res_verdict_reg, res_verdict_next;
    logic [11:0] value_prod;
    logic [2:0]  len_bump;
    logic        take;

    // a final byte needs a free result slot; others always proceed
    assign take    = q_valid && (!rd_item.last || !res_valid_reg || pop);
    assign rd_en   = take;
    assign empty   = !res_valid_reg;
    assign verdict = res_verdict_reg;

    assign value_prod = 12'(value_reg) * 12'd10 + 12'(rd_item.digit);
    assign len_bump   = (len_reg == LEN_SAT) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        v4_next    = v4_reg;
        v6_next    = v6_reg;
        dot_next   = dot_reg;
        colon_next = colon_reg;
        len_next   = len_reg;
        value_next = value_reg;
        lz_next    = lz_reg;
        case (rd_item.cls)
            CLS_DIGIT:
            begin
                if (len_reg >= V4_MAX_LEN)
                    v4_next = 1'b0;
                if (len_reg != '0 && lz_reg)
                    v4_next = 1'b0;
                if (len_reg >= V6_MAX_LEN)
                    v6_next = 1'b0;
                if (len_reg == '0 && rd_item.digit == '0)
                    lz_next = 1'b1;
                if (value_prod > 12'(V4_MAX_VALUE))
                begin
                    v4_next    = 1'b0;
                    value_next = VALUE_SAT;
                end
                else
                begin
                    value_next = value_prod[9:0];
                end
                len_next = len_bump;
            end
            CLS_HEX:
            begin
                v4_next = 1'b0;
                if (len_reg >= V6_MAX_LEN)
                    v6_next = 1'b0;
                len_next = len_bump;
            end
            CLS_DOT:
            begin
                v6_next = 1'b0;
                if (len_reg == '0)
                    v4_next = 1'b0;
                if (dot_reg == DOT_MAX)
                    v4_next = 1'b0;
                else
                    dot_next = dot_reg + 1'b1;
                len_next   = '0;
                value_next = '0;
                lz_next    = 1'b0;
            end
            CLS_COLON:
            begin
                v4_next = 1'b0;
                if (len_reg == '0)
                    v6_next = 1'b0;
                if (colon_reg == COLON_MAX)
                    v6_next = 1'b0;
                else
                    colon_next = colon_reg + 1'b1;
                len_next   = '0;
                value_next = '0;
                lz_next    = 1'b0;
            end
            default:
            begin
                v4_next = 1'b0;
                v6_next = 1'b0;
            end
        endcase
    end

    // verdict from the state after the final byte
    always_comb
    begin
        res_verdict_next = VERDICT_NONE;
        if (len_next != '0)
        begin
            if (v4_next && dot_next == DOT_MAX)
                res_verdict_next = VERDICT_V4;
            else if (v6_next && colon_next == COLON_MAX)
                res_verdict_next = VERDICT_V6;
        end
        res_valid_next = res_valid_reg;
        if (take && rd_item.last)
            res_valid_next = 1'b1;
        else if (pop)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b1;
            v6_reg        <= 1'b1;
            dot_reg       <= '0;
            colon_reg     <= '0;
            len_reg       <= '0;
            value_reg     <= '0;
            lz_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                if (rd_item.last)
                begin
                    v4_reg    <= 1'b1;
                    v6_reg    <= 1'b1;
                    dot_reg   <= '0;
                    colon_reg <= '0;
                    len_reg   <= '0;
                    value_reg <= '0;
                    lz_reg    <= 1'b0;
                end
                else
                begin
                    v4_reg    <= v4_next;
                    v6_reg    <= v6_next;
                    dot_reg   <= dot_next;
                    colon_reg <= colon_next;
                    len_reg   <= len_next;
                    value_reg <= value_next;
                    lz_reg    <= lz_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && rd_item.last)
        begin
            res_verdict_reg <= res_verdict_next;
        end
    end

    // state is fresh after every final byte
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rd_item.last) |=> (v4_reg && v6_reg && dot_reg == '0
                                    && colon_reg == '0 && len_reg == '0))
        else $error("state not cleared after final byte");

    // a ruled-out IPv4 form stays ruled out within a string
    a_v4_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !rd_item.last && !v4_reg) |=> !v4_reg)
        else $error("IPv4 candidate revived mid-string");

endmodule

[src/ip_address_text_classifier.sv]
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies an address string as IPv4, IPv6 or neither.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one ASCII byte per transfer on ch, with last high on the
//   string's final byte. A transfer happens at a clock edge with push high and
//   full low.
//   Result channel: one verdict per string (0 neither, 1 IPv4, 2 IPv6), shown
//   while empty is low and taken at an edge with pop high and empty low.
//   Bytes without last produce no result.
// Timing:
//   One byte per cycle sustained while full is low. The final byte's verdict
//   is registered: the byte lands in the queue at the transfer edge, and the
//   state update loads the result register when the back end takes it.
//   The back end retires one byte per cycle; a final byte retires only when
//   the result register is free or being popped in the same cycle.
// Stall:
//   While pop is held low, non-final bytes keep flowing; a following final
//   byte waits in the queue (DEPTH entries) and full rises once it fills.
// Reset:
//   rst_n clears the queue, empties the result register and resets the
//   classification state; full is low out of reset.
// ----------------------------------------------------------------------------
module ip_address_text_classifier #(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] verdict
);
    import ipc_pkg::*;

    logic      wr_en;
    logic      rd_en;
    logic      q_valid;
    ipc_item_t wr_item;
    ipc_item_t rd_item;

    // front: byte decode into character class and digit value
    ipc_front u_front (
        .ch_push (push),
        .ch      (ch),
        .last    (last),
        .q_full  (full),
        .wr_en   (wr_en),
        .wr_item (wr_item)
    );

    // short queue decouples byte intake from state update
    ipc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_item (wr_item),
        .rd_en   (rd_en),
        .q_full  (full),
        .q_valid (q_valid),
        .rd_item (rd_item)
    );

    // back: group/separator tracking and registered verdict
    ipc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .rd_item (rd_item),
        .rd_en   (rd_en),
        .pop     (pop),
        .empty   (empty),
        .verdict (verdict)
    );

endmodule

[tb/ip_address_text_classifier_tb.sv]
// ----------------------------------------------------------------------------
// ip_address_text_classifier_tb
// Self-checking bench for the IP address text classifier. Address strings go
// in one byte per transfer. Each verdict that comes out is compared with the
// typed verdict of a directed row or with a behavioral model of the classifier
// kept inside the bench. The directed strings come first, then random strings,
// well-formed ones and broken ones, with random gaps on both sides.
// ----------------------------------------------------------------------------
module ip_address_text_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;

    // Run sizing
    localparam int RANDOM_BYTES  = 1640;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 8;      // idle cycles after the last verdict drains
    localparam int RESET_CYCLES  = 7;

    // Directed table marker: row has no verdict typed in, the model decides
    localparam int FROM_PREDICTOR = -1;
    localparam int DIR_ROWS       = 26;

    // ------------------------------------------------------------------------
    // DUT connections, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       full;
    logic [7:0] ch    = 8'h00;
    logic       last  = 1'b0;
    logic       empty;
    logic       pop   = 1'b0;
    logic [1:0] verdict;

    ip_address_text_classifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .ch      (ch),
        .last    (last),
        .empty   (empty),
        .pop     (pop),
        .verdict (verdict)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Directed strings. Typed verdicts are the obvious ones; the rest are
    // left to the model.
    // ------------------------------------------------------------------------
    string dir_text [0:DIR_ROWS-1] = '{
        "0.0.0.0",                     // smallest IPv4
        "255.255.255.255",             // largest IPv4
        "256.1.1.1",                   // value over 255
        "01.1.1.1",                    // leading zero
        "1234.1.1.1",                  // four-digit group
        "1.2.3",                       // too few groups
        "1.2.3.4.5",                   // fourth dot
        "1..2.3",                      // empty group in the middle
        ".1.2.3",                      // separator first
        "1.2.3.4.",                    // trailing separator
        "0:0:0:0:0:0:0:0",             // smallest IPv6
        "ffff:FFFF:aBcD:0:1:2:3:9",    // widest groups, both cases
        "12345:0:0:0:0:0:0:0",         // five hex digits
        "1:2:3:4:5:6:7",               // too few groups
        "1:2:3:4:5:6:7:8:9",           // eighth colon
        "1::3:4:5:6:7:8",              // double colon
        "1.2.3:4",                     // mixed separators
        "1.2.3.4x",                    // other byte
        "g",
        "1.2.3.a",                     // hex letter in IPv4
        "1.2.3.00",                    // leading zero in last group
        "192.168.1.10",
        "fe80:0:0:0:0:0:0:1",
        "99999999.1.1.1",              // length and value both saturate
        ":",
        "9"
    };

    int dir_want [0:DIR_ROWS-1] = '{
        VERDICT_V4, VERDICT_V4, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE,
        VERDICT_NONE, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE,
        VERDICT_V6, VERDICT_V6, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE,
        VERDICT_NONE, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE, VERDICT_NONE,
        VERDICT_NONE, FROM_PREDICTOR, FROM_PREDICTOR, FROM_PREDICTOR,
        VERDICT_NONE, VERDICT_NONE
    };

    // ------------------------------------------------------------------------
    // Classifier model state
    // ------------------------------------------------------------------------
    logic       v4_ok;
    logic       v6_ok;
    logic [1:0] dots;
    logic [2:0] colons;
    logic [2:0] grp_len;
    logic [9:0] grp_val;
    logic       lead_zero;

    // Verdicts owed by the DUT, oldest first
    ipc_verdict_t verdict_fifo [$];

    // Random string under construction
    logic [7:0] text_buf [$];

    // Bookkeeping
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  byte_count     = 0;
    int  string_count   = 0;
    int  n_v4           = 0;
    int  n_v6           = 0;
    int  n_none         = 0;
    bit  tx_steady      = 1'b0;
    int  rx_run         = 0;
    int  rx_wait        = 0;
    ipc_verdict_t held_v;

    task automatic report_mismatch(input string what, input logic [1:0] got, input int want);
        $display("ERROR cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_classifier();
        v4_ok     = 1'b1;
        v6_ok     = 1'b1;
        dots      = '0;
        colons    = '0;
        grp_len   = '0;
        grp_val   = '0;
        lead_zero = 1'b0;
    endtask

    task automatic start_group();
        grp_len   = '0;
        grp_val   = '0;
        lead_zero = 1'b0;
    endtask

    // Append one byte to the string under construction
    task automatic add_char(input logic [7:0] c);
        text_buf = {text_buf, c};
    endtask

    // Advance the model by one byte; on the final byte hand back a verdict
    task automatic step_classifier(input logic [7:0] c, input logic fin,
                                   output bit produced, output ipc_verdict_t v);
        int d;
        int nv;
        produced = 1'b0;
        v        = VERDICT_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = c - CHAR_ZERO;
            if (grp_len >= V4_MAX_LEN)
                v4_ok = 1'b0;
            if (grp_len >= 3'd1 && lead_zero)
                v4_ok = 1'b0;
            if (grp_len >= V6_MAX_LEN)
                v6_ok = 1'b0;
            if (grp_len == 3'd0 && d == 0)
                lead_zero = 1'b1;
            nv = grp_val * 10 + d;
            if (nv > V4_MAX_VALUE)
            begin
                v4_ok   = 1'b0;
                grp_val = VALUE_SAT;
            end
            else
                grp_val = 10'(nv);
            if (grp_len < LEN_SAT)
                grp_len++;
        end
        else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) || (c >= CHAR_UC_A && c <= CHAR_UC_F))
        begin
            v4_ok = 1'b0;
            if (grp_len >= V6_MAX_LEN)
                v6_ok = 1'b0;
            if (grp_len < LEN_SAT)
                grp_len++;
        end
        else if (c == CHAR_DOT)
        begin
            v6_ok = 1'b0;
            if (grp_len == 3'd0)
                v4_ok = 1'b0;
            if (dots >= DOT_MAX)
                v4_ok = 1'b0;   // counter holds, no wrap
            else
                dots++;
            start_group();
        end
        else if (c == CHAR_COLON)
        begin
            v4_ok = 1'b0;
            if (grp_len == 3'd0)
                v6_ok = 1'b0;
            if (colons >= COLON_MAX)
                v6_ok = 1'b0;
            else
                colons++;
            start_group();
        end
        else
        begin
            v4_ok = 1'b0;
            v6_ok = 1'b0;
        end

        if (fin)
        begin
            produced = 1'b1;
            // an empty final group rules out both forms
            if (grp_len != 3'd0)
            begin
                if (v4_ok && dots == DOT_MAX)
                    v = VERDICT_V4;
                else if (v6_ok && colons == COLON_MAX)
                    v = VERDICT_V6;
            end
            clear_classifier();
        end
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one byte per transfer. Data changes at the falling edge;
    // the transfer is seen at the rising edge, where full still holds its
    // pre-edge value.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic fin, input int want);
        int           gap;
        bit           produced;
        ipc_verdict_t v;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        ch   <= c;
        last <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // transfer taken at this edge
        step_classifier(c, fin, produced, v);
        if (produced)
        begin
            if (want == FROM_PREDICTOR)
                verdict_fifo = {verdict_fifo, v};
            else
                verdict_fifo = {verdict_fifo, ipc_verdict_t'(want)};
        end
        byte_count++;
    endtask

    task automatic send_text(input int want);
        for (int k = 0; k < text_buf.size(); k++)
            send_byte(text_buf[k], k == text_buf.size() - 1, want);
        string_count++;
    endtask

    // ------------------------------------------------------------------------
    // Random string builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10)
            return CHAR_ZERO + 8'(n);
        else if ($urandom_range(0, 1) == 1)
            return CHAR_LC_A + 8'(n - 10);
        else
            return CHAR_UC_A + 8'(n - 10);
    endfunction

    function automatic logic [7:0] pick_sep();
        return ($urandom_range(0, 1) == 1) ? CHAR_DOT : CHAR_COLON;
    endfunction

    task automatic put_dec(input int val);
        string s;
        s = $sformatf("%0d", val);
        for (int k = 0; k < s.len(); k++)
            add_char(s[k]);
    endtask

    // Dotted form; flaw_pct is the chance per group of a broken group
    task automatic build_v4(input int groups, input int flaw_pct);
        int val;
        for (int g = 0; g < groups; g++)
        begin
            if (g > 0)
                add_char(CHAR_DOT);
            if ($urandom_range(0, 99) < flaw_pct)
            begin
                case ($urandom_range(0, 4))
                    0: ;                                        // empty group
                    1: put_dec($urandom_range(256, 9999));      // too big
                    2: begin                                    // leading zero
                        add_char(CHAR_ZERO);
                        put_dec($urandom_range(0, 99));
                    end
                    3: begin                                    // hex letter
                        put_dec($urandom_range(0, 25));
                        add_char(CHAR_LC_A + 8'($urandom_range(0, 5)));
                    end
                    default:                                    // long run, saturates
                        repeat ($urandom_range(4, 10))
                            add_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: val = 0;
                        1: val = 9;
                        2: val = 10;
                        3: val = 99;
                        4: val = 100;
                        default: val = 255;
                    endcase
                end
                else
                    val = $urandom_range(0, 255);
                put_dec(val);
            end
        end
    endtask

    // Colon form; same idea
    task automatic build_v6(input int groups, input int flaw_pct);
        for (int g = 0; g < groups; g++)
        begin
            if (g > 0)
                add_char(CHAR_COLON);
            if ($urandom_range(0, 99) < flaw_pct)
            begin
                case ($urandom_range(0, 4))
                    0: ;
                    1: repeat ($urandom_range(5, 9)) add_char(hex_char());
                    2: begin
                        add_char(hex_char());
                        add_char(CHAR_DOT);
                        add_char(hex_char());
                    end
                    3: add_char(8'($urandom_range(0, 255)));
                    default: put_dec($urandom_range(10000, 99999));
                endcase
            end
            else
                repeat ($urandom_range(1, 4)) add_char(hex_char());
        end
    endtask

    // One random edit to an otherwise clean string
    task automatic mutate_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: if (text_buf.size() > 1) text_buf.delete(pos);
            2: text_buf.insert(pos, pick_sep());
            3: add_char(pick_sep());
            default: text_buf[pos] = pick_sep();
        endcase
    endtask

    task automatic build_noise();
        string alphabet;
        alphabet = "0123456789abcdefABCDEF.:";
        repeat ($urandom_range(1, 16))
        begin
            if ($urandom_range(0, 1) == 1)
                add_char(8'($urandom_range(0, 255)));
            else
                add_char(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: pop driven at the falling edge with random stalls and
    // occasional long runs with none.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_run > 0)
        begin
            pop <= 1'b1;
            rx_run--;
        end
        else if (rx_wait > 0)
        begin
            pop <= 1'b0;
            rx_wait--;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                rx_run = $urandom_range(40, 200);
            else if ($urandom_range(0, 2) == 0)
                rx_wait = pick_gap();
        end
    end

    // Verdict check at each result transfer
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (verdict_fifo.size() == 0)
                report_mismatch("verdict with nothing pending", verdict, FROM_PREDICTOR);
            else
            begin
                held_v = verdict_fifo.pop_front();
                if (verdict !== held_v)
                    report_mismatch("verdict", verdict, held_v);
                case (held_v)
                    VERDICT_V4: n_v4++;
                    VERDICT_V6: n_v6++;
                    default:    n_none++;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts pending",
                     cycle_count, verdict_fifo.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        string s;
        int    r;
        int    random_start;

        clear_classifier();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            s = dir_text[i];
            text_buf.delete();
            for (int k = 0; k < s.len(); k++)
                add_char(s[k]);
            send_text(dir_want[i]);
        end

        // random strings, mostly well-formed with random content
        random_start = byte_count;
        while (byte_count - random_start < RANDOM_BYTES)
        begin
            text_buf.delete();
            tx_steady = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
                build_v4(4, 0);
            else if (r < 58)
                build_v6(8, 0);
            else if (r < 68)
                build_v4($urandom_range(3, 5), 25);
            else if (r < 78)
                build_v6($urandom_range(7, 9), 25);
            else if (r < 88)
            begin
                if ($urandom_range(0, 1) == 1)
                    build_v4(4, 0);
                else
                    build_v6(8, 0);
                mutate_text();
            end
            else
                build_noise();
            send_text(FROM_PREDICTOR);
        end

        @(negedge clk);
        push <= 1'b0;

        // drain, then a few idle cycles to catch anything extra
        while (verdict_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d strings, %0d bytes sent", string_count, byte_count);
        $display("verdicts checked: %0d IPv4, %0d IPv6, %0d neither; %0d mismatches in %0d cycles",
                 n_v4, n_v6, n_none, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
